@@ src/twc_pkg.sv @@
// Shared constants and types for the two-way cache tag store.
package twc_pkg;

  // Address split: byte offset, then set index, then tag.
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned SETS        = 4;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned WAYS        = 2;

  localparam int unsigned OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_BITS    = $clog2(SETS);
  localparam int unsigned TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int unsigned CNT_BITS    = 32;

  // Replacement policy select.
  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_e;

  // Outcome of one tag lookup.
  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic                way;
    logic [TAG_BITS-1:0] victim_tag;
  } lookup_t;

endpackage

@@ src/two_way_cache_tag_store_unit.sv @@
// Two-way set-associative cache tag store with LRU or FIFO replacement.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-----------------------------------------
//  in      | in  | in_valid_i / in_stall_o    | address_i
//  out     | out | out_valid_o / out_stall_i  | hit_o evicted_o way_used_o set_index_o
//          |     |                            | block_offset_o victim_tag_o *_total_o
//  cfg     | in  | cfg_we_i                   | cfg_wdata_i (replace policy)
//
// One word per cycle while out_stall_i is low; each word passes the input register, then the result register.
// The tag compare, victim pick and state update all happen in the cycle the word moves
// from the input register to the result register, so a following word to the same set
// sees the updated tags and order bits.
// Reset empties the cache, clears the order bits, counters and policy (LRU).
// A stalled result holds; the input register still takes a word while the result waits, if it is empty.
module two_way_cache_tag_store_unit
  import twc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_BITS-1:0] address_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 evicted_o,
  output logic                 way_used_o,
  output logic [SET_BITS-1:0]  set_index_o,
  output logic [OFFSET_BITS-1:0] block_offset_o,
  output logic [TAG_BITS-1:0]  victim_tag_o,
  output logic [CNT_BITS-1:0]  hit_total_o,
  output logic [CNT_BITS-1:0]  miss_total_o,
  output logic [CNT_BITS-1:0]  evict_total_o
);

  // ---------------------------------------------------------------------------
  // Control and state
  // ---------------------------------------------------------------------------
  policy_e                      policy_q;

  logic                         s1_valid_q;
  logic [ADDR_BITS-1:0]         s1_addr_q;

  logic                         out_valid_q;
  logic                         hit_q;
  logic                         evicted_q;
  logic                         way_q;
  logic [SET_BITS-1:0]          set_q;
  logic [OFFSET_BITS-1:0]       offset_q;
  logic [TAG_BITS-1:0]          victim_q;

  // Per-line valid bits (reset) and tags (no reset, only read when valid).
  logic [SETS-1:0][WAYS-1:0]    line_valid_q;
  logic [TAG_BITS-1:0]          line_tag_q [SETS][WAYS];
  // Per-set order bits: most recently used way, and the way inserted earlier.
  logic [SETS-1:0]              recent_way_q;
  logic [SETS-1:0]              oldest_way_q;

  logic [CNT_BITS-1:0]          hit_cnt_q;
  logic [CNT_BITS-1:0]          miss_cnt_q;
  logic [CNT_BITS-1:0]          evict_cnt_q;

  // ---------------------------------------------------------------------------
  // Handshake: the input register drains into the result register whenever the
  // result register is empty or its word is being taken this cycle.
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_accept;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Lookup for the word in the input register
  // ---------------------------------------------------------------------------
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [SET_BITS-1:0]    cur_set;
  logic [TAG_BITS-1:0]    cur_tag;
  logic                   hit0;
  logic                   hit1;
  logic                   victim_way;
  lookup_t                lk;

  assign cur_offset = s1_addr_q[OFFSET_BITS-1:0];
  assign cur_set    = s1_addr_q[OFFSET_BITS +: SET_BITS];
  assign cur_tag    = s1_addr_q[ADDR_BITS-1 -: TAG_BITS];

  assign hit0 = line_valid_q[cur_set][0] && (line_tag_q[cur_set][0] == cur_tag);
  assign hit1 = line_valid_q[cur_set][1] && (line_tag_q[cur_set][1] == cur_tag);

  // Victim in a full set: LRU evicts the way not used last, FIFO the older insert.
  assign victim_way = (policy_q == POLICY_FIFO) ? oldest_way_q[cur_set]
                                                : ~recent_way_q[cur_set];

  always_comb begin
    lk            = '0;
    lk.hit        = hit0 || hit1;
    if (hit0) begin
      lk.way = 1'b0;
    end else if (hit1) begin
      lk.way = 1'b1;
    end else if (!line_valid_q[cur_set][0]) begin
      lk.way = 1'b0;
    end else if (!line_valid_q[cur_set][1]) begin
      lk.way = 1'b1;
    end else begin
      lk.way        = victim_way;
      lk.evicted    = 1'b1;
      lk.victim_tag = line_tag_q[cur_set][victim_way];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= POLICY_LRU;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      line_valid_q <= '0;
      recent_way_q <= '0;
      oldest_way_q <= '0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      evict_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        policy_q <= policy_e'(cfg_wdata_i);
      end

      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (advance) begin
        recent_way_q[cur_set] <= lk.way;
        if (lk.hit) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + 1'b1;
          end
        end else begin
          line_valid_q[cur_set][lk.way] <= 1'b1;
          oldest_way_q[cur_set]         <= ~lk.way;
          if (miss_cnt_q != '1) begin
            miss_cnt_q <= miss_cnt_q + 1'b1;
          end
          if (lk.evicted && (evict_cnt_q != '1)) begin
            evict_cnt_q <= evict_cnt_q + 1'b1;
          end
        end
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_addr_q <= address_i;
    end
    if (advance) begin
      hit_q     <= lk.hit;
      evicted_q <= lk.evicted;
      way_q     <= lk.way;
      set_q     <= cur_set;
      offset_q  <= cur_offset;
      victim_q  <= lk.victim_tag;
      if (!lk.hit) begin
        line_tag_q[cur_set][lk.way] <= cur_tag;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs. The counters only move when a word enters the result register, so
  // while that word waits they still hold the totals including it.
  // ---------------------------------------------------------------------------
  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign evicted_o      = evicted_q;
  assign way_used_o     = way_q;
  assign set_index_o    = set_q;
  assign block_offset_o = offset_q;
  assign victim_tag_o   = victim_q;
  assign hit_total_o    = hit_cnt_q;
  assign miss_total_o   = miss_cnt_q;
  assign evict_total_o  = evict_cnt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> !evicted_q && (victim_q == '0))
    else $error("hit result reports an eviction");

  a_line_valid_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> line_valid_q[$past(cur_set)][$past(lk.way)])
    else $error("used way not valid after lookup");

  a_evict_full_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && lk.evicted |-> (line_valid_q[cur_set] == '1) && !lk.hit)
    else $error("eviction from a set that is not full");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(hit_cnt_q) && $stable(miss_cnt_q) && $stable(evict_cnt_q))
    else $error("counter moved without a lookup");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_addr_q))
    else $error("stalled input word lost");

endmodule
